FILE: rtl/core/snz_pkg.sv
// Shared constants, types and the gradient table for the 2D simplex noise core.
package snz_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS   = 15;

    localparam int Q_FRAC = 24;     // internal fraction bits
    localparam int DW     = 28;     // corner offset width, Q.24 signed
    localparam int CW     = 28;     // per-corner contribution width
    localparam int GW     = 26;     // gradient component width
    localparam int NW     = 27;     // normalization width

    localparam longint ONE_Q    = 64'sd1 <<< Q_FRAC;
    localparam longint HALF_Q   = 64'sd1 <<< (Q_FRAC - 1);
    localparam longint SKEW_Q   = 6140887;
    localparam longint UNSKEW_Q = 3545443;
    localparam longint THIRD_Q  = -9686330;
    localparam longint NORM_A_Q = 30078913;
    localparam longint NORM_B_Q = 14323292;

    localparam int HASH_MOD  = 289;
    localparam int HASH_MUL  = 34;
    localparam int GRAD_DIV  = 41;
    localparam int OUT_SCALE = 130;

    localparam int LATENCY   = 24;  // accept edge to result strobe
    localparam int HASH_WAIT = 4;   // corner falloff waits this long for the hash

    typedef struct packed {
        logic signed [GW-1:0] a0;
        logic signed [GW-1:0] h;
        logic signed [NW-1:0] norm;
    } t_grad;

    typedef t_grad [GRAD_DIV-1:0] t_grad_tab;

    // Gradient and normalization for one hash residue mod 41 (a 41-entry table).
    function automatic t_grad grad_of(logic [5:0] r);
        longint gx;
        longint hh;
        longint ox;
        longint a0;
        longint sq;
        longint nv;
        t_grad  g;
        gx = ((longint'(r) * 2) * ONE_Q) / GRAD_DIV - ONE_Q;
        hh = ((gx < 0) ? -gx : gx) - HALF_Q;
        ox = (gx + HALF_Q) >>> Q_FRAC;
        a0 = gx - ox * ONE_Q;
        sq = ((a0 * a0) >>> Q_FRAC) + ((hh * hh) >>> Q_FRAC);
        nv = NORM_A_Q - ((NORM_B_Q * sq) >>> Q_FRAC);
        g.a0   = GW'(a0);
        g.h    = GW'(hh);
        g.norm = NW'(nv);
        return g;
    endfunction

    function automatic t_grad_tab grad_table();
        t_grad_tab tab;
        for (int i = 0; i < GRAD_DIV; i++) begin
            tab[i] = grad_of(6'(i));
        end
        return tab;
    endfunction

    localparam t_grad_tab GRAD_TAB = grad_table();

endpackage

FILE: rtl/core/snz_mod289.sv
// Three-stage reduction modulo 289 by reciprocal multiply and one correction.
module snz_mod289 #(
    parameter int W = 22
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_val,
    output logic [8:0]   o_rem
);

    localparam int     S     = W + 1;
    localparam int     RW    = S - 7;
    localparam longint RECIP = (64'sd1 <<< S) / snz_pkg::HASH_MOD;

    logic [W-1:0]    r_val;
    logic [W+RW-1:0] r_prod;
    logic [9:0]      r_part;
    logic [8:0]      r_rem;
    logic [W-1:0]    quot;
    logic [W+9:0]    qm;
    logic [W-1:0]    diff;

    // quotient estimate is exact or one low, so the remainder stays below 578
    always_comb begin
        quot = W'(r_prod >> S);
        qm   = (W+10)'(quot) * (W+10)'(snz_pkg::HASH_MOD);
        diff = r_val - W'(qm);
    end

    always_ff @(posedge i_clk) begin
        r_val  <= i_val;
        r_prod <= (W+RW)'(i_val) * (W+RW)'(RECIP);
        r_part <= diff[9:0];
        if (r_part >= 10'(snz_pkg::HASH_MOD)) begin
            r_rem <= 9'(r_part - 10'(snz_pkg::HASH_MOD));
        end else begin
            r_rem <= r_part[8:0];
        end
    end

    assign o_rem = r_rem;

endmodule

FILE: rtl/core/snz_hash.sv
// Permutation polynomial (34k+1)k mod 289, four pipeline stages.
module snz_hash (
    input  logic       i_clk,
    input  logic [9:0] i_k,
    output logic [8:0] o_p
);

    logic [8:0]  k_red;
    logic [21:0] r_poly;

    // argument is below 3*289, fold it into 0..288 first
    always_comb begin
        if (i_k >= 10'(2 * snz_pkg::HASH_MOD)) begin
            k_red = 9'(i_k - 10'(2 * snz_pkg::HASH_MOD));
        end else if (i_k >= 10'(snz_pkg::HASH_MOD)) begin
            k_red = 9'(i_k - 10'(snz_pkg::HASH_MOD));
        end else begin
            k_red = i_k[8:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_poly <= (22'(k_red) * 22'(snz_pkg::HASH_MUL) + 22'd1) * 22'(k_red);
    end

    snz_mod289 #(.W(22)) u_mod (
        .i_clk (i_clk),
        .i_val (r_poly),
        .o_rem (o_p)
    );

endmodule

FILE: rtl/core/snz_corner.sv
// One simplex corner: radial falloff, gradient lookup and contribution.
module snz_corner (
    input  logic                          i_clk,
    input  logic signed [snz_pkg::DW-1:0] i_dx,
    input  logic signed [snz_pkg::DW-1:0] i_dy,
    input  logic [8:0]                    i_p,
    output logic signed [snz_pkg::CW-1:0] o_c
);

    localparam int DW   = snz_pkg::DW;
    localparam int CW   = snz_pkg::CW;
    localparam int QF   = snz_pkg::Q_FRAC;
    localparam int WAIT = snz_pkg::HASH_WAIT;
    localparam int DDLY = 5 + WAIT;
    localparam int QMAX = (snz_pkg::HASH_MOD - 1) / snz_pkg::GRAD_DIV;
    localparam logic signed [29:0] HALF = 30'(snz_pkg::HALF_Q);

    logic signed [DW-1:0]   r_dx_d [DDLY];
    logic signed [DW-1:0]   r_dy_d [DDLY];
    logic signed [DW-1:0]   r_sxx;
    logic signed [DW-1:0]   r_syy;
    logic [23:0]            r_m;
    logic [22:0]            r_m2;
    logic [20:0]            r_m4;
    logic [20:0]            r_m4_d [WAIT];
    logic [20:0]            r_m4_5;
    snz_pkg::t_grad         r_grad;
    logic signed [22:0]     r_m5;
    logic signed [22:0]     r_m5_7;
    logic signed [DW-1:0]   r_ga;
    logic signed [DW-1:0]   r_gb;
    logic signed [DW:0]     r_g;
    logic signed [CW-1:0]   r_c;

    logic signed [2*DW-1:0] sq_x;
    logic signed [2*DW-1:0] sq_y;
    logic signed [29:0]     mt;
    logic [47:0]            p_m2;
    logic [45:0]            p_m4;
    logic [2:0]             quo;
    logic [5:0]             rem;
    logic signed [48:0]     p_m5;
    logic signed [53:0]     p_ga;
    logic signed [53:0]     p_gb;
    logic signed [51:0]     p_c;

    always_comb begin
        sq_x = i_dx * i_dx;
        sq_y = i_dy * i_dy;
        mt   = HALF - (30'(r_sxx) + 30'(r_syy));
        p_m2 = 48'(r_m) * 48'(r_m);
        p_m4 = 46'(r_m2) * 46'(r_m2);
        // hash mod 41 by counting thresholds
        quo = '0;
        for (int j = 1; j <= QMAX; j++) begin
            if (i_p >= 9'(j * snz_pkg::GRAD_DIV)) begin
                quo = quo + 3'd1;
            end
        end
        rem  = 6'(i_p - 9'(quo) * 9'(snz_pkg::GRAD_DIV));
        p_m5 = $signed({1'b0, r_m4_5}) * r_grad.norm;
        p_ga = r_grad.a0 * r_dx_d[DDLY-1];
        p_gb = r_grad.h * r_dy_d[DDLY-1];
        p_c  = r_m5_7 * r_g;
    end

    always_ff @(posedge i_clk) begin
        r_dx_d[0] <= i_dx;
        r_dy_d[0] <= i_dy;
        for (int i = 1; i < DDLY; i++) begin
            r_dx_d[i] <= r_dx_d[i-1];
            r_dy_d[i] <= r_dy_d[i-1];
        end
        r_sxx <= DW'(sq_x >>> QF);
        r_syy <= DW'(sq_y >>> QF);
        if (mt < 0) begin
            r_m <= '0;
        end else begin
            r_m <= mt[23:0];
        end
        r_m2 <= 23'(p_m2 >> QF);
        r_m4 <= 21'(p_m4 >> QF);
        r_m4_d[0] <= r_m4;
        for (int i = 1; i < WAIT; i++) begin
            r_m4_d[i] <= r_m4_d[i-1];
        end
        r_m4_5 <= r_m4_d[WAIT-1];
        r_grad <= snz_pkg::GRAD_TAB[rem];
        r_m5   <= 23'(p_m5 >>> QF);
        r_ga   <= DW'(p_ga >>> QF);
        r_gb   <= DW'(p_gb >>> QF);
        r_g    <= (DW+1)'(r_ga) + (DW+1)'(r_gb);
        r_m5_7 <= r_m5;
        r_c    <= CW'(p_c >>> QF);
    end

    assign o_c = r_c;

endmodule

FILE: rtl/core/simplex_noise_2d_core.sv
// Top level of the pipelined 2D simplex noise core.
//
// Usage: drive i_coord_x / i_coord_y (signed fixed point, COORD_FRAC_BITS
// fraction bits) and raise start; a request is taken at each rising edge
// where start is high and busy is low. busy is high only during reset, so
// a new request can be taken every cycle.
// Each request yields one o_noise_value (signed, OUT_FRAC_BITS fraction
// bits, saturated), shown for one cycle with o_done high.
// Results come out in request order.
// Throughput: one sample per clock outside reset. The latency is set by
// the chain of skew multiply, two cascaded mod-289 hash pipelines and
// the corner falloff multiplies.
// The receiver cannot stall; the pipeline never holds.
// Reset (i_rst_n low, synchronous) drops all requests in flight and keeps
// busy high while it is asserted. There is no other state.
module simplex_noise_2d_core #(
    parameter int COORD_FRAC_BITS = snz_pkg::COORD_FRAC_BITS,
    parameter int OUT_FRAC_BITS   = snz_pkg::OUT_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    output logic               o_done,
    output logic signed [15:0] o_noise_value
);

    localparam int QF  = snz_pkg::Q_FRAC;
    localparam int DW  = snz_pkg::DW;
    localparam int CW  = snz_pkg::CW;
    localparam int LAT = snz_pkg::LATENCY;
    localparam int VW  = 32 + QF - COORD_FRAC_BITS;
    localparam int SW  = VW + 1;
    localparam int IW  = SW + 1 - QF;
    localparam int TW  = IW + 24;
    localparam int XW  = IW + 26;
    localparam int SH  = QF - OUT_FRAC_BITS;
    localparam int SCW = CW + 10;

    localparam logic signed [23:0] SKEW_S   = 24'(snz_pkg::SKEW_Q);
    localparam logic [22:0]        SKEW_U   = 23'(snz_pkg::SKEW_Q);
    localparam logic signed [23:0] UNSKEW_S = 24'(snz_pkg::UNSKEW_Q);
    localparam logic signed [DW-1:0] ONE_D    = DW'(snz_pkg::ONE_Q);
    localparam logic signed [DW-1:0] UNSKEW_D = DW'(snz_pkg::UNSKEW_Q);
    localparam logic signed [DW-1:0] THIRD_D  = DW'(snz_pkg::THIRD_Q);
    // multiple of 289 at least 2^(IW-1): 289 < 2^9
    localparam logic signed [IW+1:0] MOD_OFF =
        (IW+2)'(longint'(snz_pkg::HASH_MOD) <<< (IW - 9));
    localparam logic signed [SCW-1:0] RND     = SCW'(64'sd1 <<< (SH - 1));
    localparam logic signed [SCW-1:0] OUT_MAX = SCW'(32767);
    localparam logic signed [SCW-1:0] OUT_MIN = -SCW'(32768);

    logic [LAT-1:0]        r_vld;
    logic signed [31:0]    r_in_x;
    logic signed [31:0]    r_in_y;
    logic signed [VW-1:0]  r_vx [6];
    logic signed [VW-1:0]  r_vy [6];
    logic signed [SW-1:0]  r_s;
    logic signed [SW-1:0]  r_ph;
    logic [22:0]           r_pl;
    logic signed [SW-1:0]  r_sk;
    logic signed [IW-1:0]  r_ix;
    logic signed [IW-1:0]  r_iy;
    logic signed [IW-1:0]  r_ix_d [2];
    logic signed [IW-1:0]  r_iy_d [2];
    logic signed [IW:0]    r_isum;
    logic signed [TW-1:0]  r_t;
    logic signed [DW-1:0]  r_x0x;
    logic signed [DW-1:0]  r_x0y;
    logic signed [DW-1:0]  r_c0x;
    logic signed [DW-1:0]  r_c0y;
    logic signed [DW-1:0]  r_c1x;
    logic signed [DW-1:0]  r_c1y;
    logic signed [DW-1:0]  r_c2x;
    logic signed [DW-1:0]  r_c2y;
    logic                  r_sx_d [4];
    logic [8:0]            r_cx_d [4];
    logic [9:0]            r_k0;
    logic [9:0]            r_k1;
    logic [9:0]            r_k2;
    logic signed [CW+1:0]  r_sum;
    logic signed [SCW-1:0] r_rnd;
    logic signed [15:0]    r_out;

    logic signed [VW-1:0]  c_vx;
    logic signed [VW-1:0]  c_vy;
    logic signed [SW-1:0]  c_ph;
    logic [46:0]           c_pl;
    logic signed [SW:0]    c_fx;
    logic signed [SW:0]    c_fy;
    logic signed [TW-1:0]  c_t;
    logic signed [XW-1:0]  c_x0x;
    logic signed [XW-1:0]  c_x0y;
    logic                  c_sx;
    logic signed [IW+1:0]  c_ux;
    logic signed [IW+1:0]  c_uy;
    logic [8:0]            cx;
    logic [8:0]            cy;
    logic [8:0]            hy0;
    logic [8:0]            hy1;
    logic [8:0]            hsel;
    logic [8:0]            p0;
    logic [8:0]            p1;
    logic [8:0]            p2;
    logic signed [CW-1:0]  k0c;
    logic signed [CW-1:0]  k1c;
    logic signed [CW-1:0]  k2c;
    logic signed [SCW-1:0] c_sc;

    assign busy = ~i_rst_n;

    always_comb begin
        c_vx  = VW'(r_in_x) <<< (QF - COORD_FRAC_BITS);
        c_vy  = VW'(r_in_y) <<< (QF - COORD_FRAC_BITS);
        c_ph  = $signed(r_s[SW-1:QF]) * SKEW_S;
        c_pl  = r_s[QF-1:0] * SKEW_U;
        c_fx  = (SW+1)'(r_vx[2]) + (SW+1)'(r_sk);
        c_fy  = (SW+1)'(r_vy[2]) + (SW+1)'(r_sk);
        c_t   = r_isum * UNSKEW_S;
        c_x0x = XW'(r_vx[5]) - XW'($signed({r_ix_d[1], QF'(0)})) + XW'(r_t);
        c_x0y = XW'(r_vy[5]) - XW'($signed({r_iy_d[1], QF'(0)})) + XW'(r_t);
        c_sx  = (r_x0x > r_x0y);
        c_ux  = (IW+2)'(r_ix) + MOD_OFF;
        c_uy  = (IW+2)'(r_iy) + MOD_OFF;
        // middle corner row: cy+1 when stepping in y
        hsel  = r_sx_d[3] ? hy0 : hy1;
        c_sc  = SCW'(r_sum) * SCW'(snz_pkg::OUT_SCALE) + RND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_x <= i_coord_x;
        r_in_y <= i_coord_y;
        r_vx[0] <= c_vx;
        r_vy[0] <= c_vy;
        for (int i = 1; i < 6; i++) begin
            r_vx[i] <= r_vx[i-1];
            r_vy[i] <= r_vy[i-1];
        end
        r_s    <= SW'(c_vx) + SW'(c_vy);
        r_ph   <= c_ph;
        r_pl   <= c_pl[46:QF];
        r_sk   <= r_ph + SW'($signed({1'b0, r_pl}));
        r_ix   <= c_fx[SW:QF];
        r_iy   <= c_fy[SW:QF];
        r_ix_d[0] <= r_ix;
        r_iy_d[0] <= r_iy;
        r_ix_d[1] <= r_ix_d[0];
        r_iy_d[1] <= r_iy_d[0];
        r_isum <= (IW+1)'(r_ix) + (IW+1)'(r_iy);
        r_t    <= c_t;
        r_x0x  <= c_x0x[DW-1:0];
        r_x0y  <= c_x0y[DW-1:0];
        r_c0x  <= r_x0x;
        r_c0y  <= r_x0y;
        r_c1x  <= r_x0x - (c_sx ? ONE_D : '0) + UNSKEW_D;
        r_c1y  <= r_x0y - (c_sx ? '0 : ONE_D) + UNSKEW_D;
        r_c2x  <= r_x0x + THIRD_D;
        r_c2y  <= r_x0y + THIRD_D;
        r_sx_d[0] <= c_sx;
        r_cx_d[0] <= cx;
        for (int i = 1; i < 4; i++) begin
            r_sx_d[i] <= r_sx_d[i-1];
            r_cx_d[i] <= r_cx_d[i-1];
        end
        r_k0  <= 10'(hy0) + 10'(r_cx_d[3]);
        r_k1  <= 10'(hsel) + 10'(r_cx_d[3]) + 10'(r_sx_d[3]);
        r_k2  <= 10'(hy1) + 10'(r_cx_d[3]) + 10'd1;
        r_sum <= (CW+2)'(k0c) + (CW+2)'(k1c) + (CW+2)'(k2c);
        r_rnd <= c_sc >>> SH;
        if (r_rnd > OUT_MAX) begin
            r_out <= 16'(OUT_MAX);
        end else if (r_rnd < OUT_MIN) begin
            r_out <= 16'(OUT_MIN);
        end else begin
            r_out <= r_rnd[15:0];
        end
    end

    snz_mod289 #(.W(IW + 1)) u_mod_x (
        .i_clk (i_clk),
        .i_val (c_ux[IW:0]),
        .o_rem (cx)
    );

    snz_mod289 #(.W(IW + 1)) u_mod_y (
        .i_clk (i_clk),
        .i_val (c_uy[IW:0]),
        .o_rem (cy)
    );

    snz_hash u_hash_y0 (.i_clk(i_clk), .i_k(10'(cy)), .o_p(hy0));
    snz_hash u_hash_y1 (.i_clk(i_clk), .i_k(10'(cy) + 10'd1), .o_p(hy1));

    snz_hash u_hash_p0 (.i_clk(i_clk), .i_k(r_k0), .o_p(p0));
    snz_hash u_hash_p1 (.i_clk(i_clk), .i_k(r_k1), .o_p(p1));
    snz_hash u_hash_p2 (.i_clk(i_clk), .i_k(r_k2), .o_p(p2));

    snz_corner u_corner0 (
        .i_clk (i_clk),
        .i_dx  (r_c0x),
        .i_dy  (r_c0y),
        .i_p   (p0),
        .o_c   (k0c)
    );

    snz_corner u_corner1 (
        .i_clk (i_clk),
        .i_dx  (r_c1x),
        .i_dy  (r_c1y),
        .i_p   (p1),
        .o_c   (k1c)
    );

    snz_corner u_corner2 (
        .i_clk (i_clk),
        .i_dx  (r_c2x),
        .i_dy  (r_c2y),
        .i_p   (p2),
        .o_c   (k2c)
    );

    assign o_done        = r_vld[LAT-1];
    assign o_noise_value = r_out;

    // every request comes out after the fixed latency
    a_req_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("request without result");

    // no result without a request
    a_done_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without request");

endmodule
